// ===== src/fmeq_pkg.sv =====
`default_nettype none

package fmeq_pkg;

  localparam logic CMD_DELIVER = 1'b0;
  localparam logic CMD_TAKE    = 1'b1;

  localparam logic [2:0] ST_TAKEN     = 3'd0;
  localparam logic [2:0] ST_NO_MATCH  = 3'd1;
  localparam logic [2:0] ST_MISSING   = 3'd2;
  localparam logic [2:0] ST_DELIVERED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         match_mode;
    logic [3:0]         item_type;
    logic signed [31:0] item_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               has_type;
    logic               has_min;
    logic               has_max;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         out_type;
    logic signed [31:0] out_value;
    logic               not_empty;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic take;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_PICK
  } state_t;

endpackage

`default_nettype wire

// ===== src/first_match_extract_queue_top.sv =====
// First-match extract queue: an ordered store of up to DEPTH items (type, value).
// Request channel (req_valid / req_stall / req): cmd deliver appends an item at
// the tail or drops it when full; cmd take removes the oldest item matching the
// mode (any, value window, type, or both) and the items behind it move up.
// Response channel (rsp_valid / rsp_stall / rsp): one response per request with
// status, the taken item, and whether the store is non-empty afterwards.
// Each transaction passes through accept, a match step in which every cell
// compares itself against the request, and a commit step in which the first
// hit is picked and the cells behind it shift one place toward the head.
// The response is registered by the commit step; no new request is accepted
// until that commit, as req_stall is high during the match and commit steps.
// The response register lets the next request be accepted while a response
// waits; when rsp_stall holds, the commit step waits until the response
// register frees up. Reset empties the store and drops any pending response;
// item storage is not cleared.
`default_nettype none

module first_match_extract_queue_top
  import fmeq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int TYPE_BITS  = 4,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

  state_t              state;
  state_t              state_next;
  req_t                held;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  rsp_t                result;
  cell_ctl_t           ctl;

  logic [TYPE_BITS-1:0]         want_type;
  logic signed [VALUE_BITS-1:0] new_value;
  logic signed [VALUE_BITS-1:0] lo;
  logic signed [VALUE_BITS-1:0] hi;

  logic [DEPTH-1:0]             match;
  logic [DEPTH-1:0]             prefix;
  logic [TYPE_BITS-1:0]         types  [DEPTH];
  logic signed [VALUE_BITS-1:0] values [DEPTH];
  logic                         found;
  logic [TYPE_BITS-1:0]         sel_type;
  logic signed [VALUE_BITS-1:0] sel_value;

  logic out_free;
  logic is_take;
  logic full;
  logic empty;
  logic missing;
  logic do_commit;

  assign want_type = TYPE_BITS'(held.item_type);
  assign new_value = VALUE_BITS'(held.item_value);
  assign lo        = VALUE_BITS'(held.min_value);
  assign hi        = VALUE_BITS'(held.max_value);

  assign out_free = !rsp_valid || !rsp_stall;
  assign is_take  = held.cmd == CMD_TAKE;
  assign full     = count == FULL_COUNT;
  assign empty    = count == '0;
  assign missing  = (held.match_mode[1] && !held.has_type)
                 || (held.match_mode[0] && !(held.has_min && held.has_max));

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [TYPE_BITS-1:0]         nb_type;
      logic signed [VALUE_BITS-1:0] nb_value;

      if (g == DEPTH - 1) begin : g_tail
        assign nb_type  = types[g];
        assign nb_value = values[g];
      end else begin : g_inner
        assign nb_type  = types[g+1];
        assign nb_value = values[g+1];
      end

      fmeq_cell #(
        .TYPE_BITS (TYPE_BITS),
        .VALUE_BITS(VALUE_BITS),
        .CNT_BITS  (CNT_BITS),
        .INDEX     (g)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .count      (count),
        .prefix     (prefix[g]),
        .mode       (held.match_mode),
        .want_type  (want_type),
        .new_value  (new_value),
        .lo         (lo),
        .hi         (hi),
        .nb_type    (nb_type),
        .nb_value   (nb_value),
        .entry_type (types[g]),
        .entry_value(values[g]),
        .match      (match[g])
      );
    end
  endgenerate

  fmeq_pick #(
    .DEPTH     (DEPTH),
    .TYPE_BITS (TYPE_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_pick (
    .match    (match),
    .types    (types),
    .values   (values),
    .prefix   (prefix),
    .found    (found),
    .sel_type (sel_type),
    .sel_value(sel_value)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_MATCH;
      end
      S_MATCH: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = state != S_IDLE;
    do_commit   = (state == S_PICK) && out_free;
    ctl.capture = state == S_MATCH;
    ctl.take    = is_take;
    ctl.commit  = do_commit && (is_take ? (!empty && !missing && found) : !full);
  end

  always_comb begin
    result           = '0;
    count_next       = count;
    if (!is_take) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        result.status = ST_DELIVERED;
        count_next    = count + CNT_BITS'(1);
      end
    end else if (empty) begin
      result.status = ST_NO_MATCH;
    end else if (missing) begin
      result.status = ST_MISSING;
    end else if (!found) begin
      result.status = ST_NO_MATCH;
    end else begin
      result.status    = ST_TAKEN;
      result.out_type  = 4'(sel_type);
      result.out_value = 32'(sel_value);
      count_next       = count - CNT_BITS'(1);
    end
    result.not_empty = count_next != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      held <= req;
    end
    if (do_commit) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

// ===== src/fmeq_cell.sv =====
`default_nettype none

module fmeq_cell
  import fmeq_pkg::*;
#(
  parameter int TYPE_BITS  = 4,
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS   = 7,
  parameter int INDEX      = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cell_ctl_t                    ctl,
  input  wire logic [CNT_BITS-1:0]          count,
  input  wire logic                         prefix,
  input  wire logic [1:0]                   mode,
  input  wire logic [TYPE_BITS-1:0]         want_type,
  input  wire logic signed [VALUE_BITS-1:0] new_value,
  input  wire logic signed [VALUE_BITS-1:0] lo,
  input  wire logic signed [VALUE_BITS-1:0] hi,
  input  wire logic [TYPE_BITS-1:0]         nb_type,
  input  wire logic signed [VALUE_BITS-1:0] nb_value,
  output logic [TYPE_BITS-1:0]              entry_type,
  output logic signed [VALUE_BITS-1:0]      entry_value,
  output logic                              match
);

  localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

  logic occupied;
  logic type_ok;
  logic win_ok;

  assign occupied = MY_INDEX < count;
  assign type_ok  = !mode[1] || (entry_type == want_type);
  assign win_ok   = !mode[0] || ((entry_value >= lo) && (entry_value <= hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.capture) begin
      match <= occupied && type_ok && win_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && ctl.take && prefix) begin
      entry_type  <= nb_type;
      entry_value <= nb_value;
    end else if (ctl.commit && !ctl.take && (count == MY_INDEX)) begin
      entry_type  <= want_type;
      entry_value <= new_value;
    end
  end

endmodule

`default_nettype wire

// ===== src/fmeq_pick.sv =====
`default_nettype none

module fmeq_pick #(
  parameter int DEPTH      = 64,
  parameter int TYPE_BITS  = 4,
  parameter int VALUE_BITS = 32
) (
  input  wire logic [DEPTH-1:0]             match,
  input  wire logic [TYPE_BITS-1:0]         types [DEPTH],
  input  wire logic signed [VALUE_BITS-1:0] values [DEPTH],
  output logic [DEPTH-1:0]                  prefix,
  output logic                              found,
  output logic [TYPE_BITS-1:0]              sel_type,
  output logic signed [VALUE_BITS-1:0]      sel_value
);

  logic [DEPTH-1:0] neg;
  logic [DEPTH-1:0] first;

  assign neg    = ~match + DEPTH'(1);
  assign prefix = match | neg;
  assign first  = match & neg;
  assign found  = |match;

  always_comb begin
    sel_type  = '0;
    sel_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_type  = sel_type  | (types[i]  & {TYPE_BITS{first[i]}});
      sel_value = sel_value | (values[i] & {VALUE_BITS{first[i]}});
    end
  end

endmodule

`default_nettype wire

// ===== dv/first_match_extract_queue_top_tb.sv =====
`timescale 1ns / 1ps

module first_match_extract_queue_top_tb;
  import fmeq_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [1:0] MODE_ANY    = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_TYPE   = 2'd2;
  localparam logic [1:0] MODE_BOTH   = 2'd3;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t request_q[$];
  rsp_t predicted_rsp_q[$];
  rsp_t want_rsp;

  logic [3:0]         store_type[STORE_DEPTH];
  logic signed [31:0] store_value[STORE_DEPTH];
  int                 store_fill = 0;

  int accepted_cnt = 0;
  int total_items = 0;
  int error_cnt = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  first_match_extract_queue_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int hit;
    logic need_type;
    logic need_win;
    o = '0;
    if (r.cmd == CMD_DELIVER) begin
      if (store_fill >= STORE_DEPTH) begin
        o.status = ST_FULL;
      end else begin
        store_type[store_fill] = r.item_type;
        store_value[store_fill] = r.item_value;
        store_fill++;
        o.status = ST_DELIVERED;
      end
    end else if (store_fill == 0) begin
      o.status = ST_NO_MATCH;
    end else begin
      need_type = r.match_mode[1];
      need_win = r.match_mode[0];
      if ((need_type && !r.has_type) || (need_win && !(r.has_min && r.has_max))) begin
        o.status = ST_MISSING;
      end else begin
        hit = -1;
        for (int i = 0; i < store_fill; i++) begin
          if (hit < 0 && (!need_type || store_type[i] == r.item_type) &&
              (!need_win || ($signed(store_value[i]) >= $signed(r.min_value) &&
                             $signed(store_value[i]) <= $signed(r.max_value)))) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          o.status = ST_NO_MATCH;
        end else begin
          o.status = ST_TAKEN;
          o.out_type = store_type[hit];
          o.out_value = store_value[hit];
          for (int i = hit; i + 1 < store_fill; i++) begin
            store_type[i] = store_type[i + 1];
            store_value[i] = store_value[i + 1];
          end
          store_fill--;
        end
      end
    end
    o.not_empty = (store_fill != 0);
    return o;
  endfunction

  function automatic int idle_pct(input bit receiver_side);
    if (accepted_cnt < total_items / 3) begin
      return receiver_side ? 83 : 13;
    end else if (accepted_cnt < 2 * total_items / 3) begin
      return receiver_side ? 13 : 83;
    end
    return 0;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return $urandom;
      default: return $signed($urandom_range(40)) - 20;
    endcase
  endfunction

  function automatic logic [3:0] rand_type();
    if ($urandom_range(9) < 7) begin
      return 4'($urandom_range(3));
    end
    return 4'($urandom_range(15));
  endfunction

  task automatic push_deliver(input logic [3:0] t, input logic signed [31:0] v);
    req_t r;
    r.cmd = CMD_DELIVER;
    r.match_mode = 2'($urandom_range(3));
    r.item_type = t;
    r.item_value = v;
    r.min_value = $urandom;
    r.max_value = $urandom;
    r.has_type = 1'($urandom_range(1));
    r.has_min = 1'($urandom_range(1));
    r.has_max = 1'($urandom_range(1));
    request_q = {request_q, r};
  endtask

  task automatic push_take(input logic [1:0] m, input logic [3:0] t,
                           input logic signed [31:0] lo, input logic signed [31:0] hi,
                           input logic ht, input logic hmn, input logic hmx);
    req_t r;
    r.cmd = CMD_TAKE;
    r.match_mode = m;
    r.item_type = t;
    r.item_value = $urandom;
    r.min_value = lo;
    r.max_value = hi;
    r.has_type = ht;
    r.has_min = hmn;
    r.has_max = hmx;
    request_q = {request_q, r};
  endtask

  task automatic push_random_take(input bit well_formed);
    logic [1:0] m;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    m = 2'($urandom_range(3));
    lo = rand_value();
    case ($urandom_range(6))
      0: hi = VAL_MAX;
      1: hi = rand_value();
      default: hi = lo + $urandom_range(40);
    endcase
    if (well_formed) begin
      push_take(m, rand_type(), lo, hi, m[1] | 1'($urandom_range(1)),
                m[0] | 1'($urandom_range(1)), m[0] | 1'($urandom_range(1)));
    end else begin
      push_take(m, rand_type(), lo, hi, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    error_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        predicted_rsp_q = {predicted_rsp_q, apply_request(req)};
        accepted_cnt <= accepted_cnt + 1;
      end
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        req_valid <= 1'b1;
        req <= request_q.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // hold off the response side long enough to back up the request channel
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (!holdoff_done && accepted_cnt >= 150) begin
        holdoff_left <= 400;
        holdoff_done <= 1'b1;
      end else if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
      end
      rsp_stall <= (holdoff_left != 0) || ($urandom_range(99) < idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (predicted_rsp_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0h", $time, rsp);
        error_cnt++;
      end else begin
        want_rsp = predicted_rsp_q.pop_front();
        if (rsp.status !== want_rsp.status)
          report_field("status", 32'(want_rsp.status), 32'(rsp.status));
        if (rsp.out_type !== want_rsp.out_type)
          report_field("out_type", 32'(want_rsp.out_type), 32'(rsp.out_type));
        if (rsp.out_value !== want_rsp.out_value)
          report_field("out_value", want_rsp.out_value, rsp.out_value);
        if (rsp.not_empty !== want_rsp.not_empty)
          report_field("not_empty", 32'(want_rsp.not_empty), 32'(rsp.not_empty));
      end
    end
  end

  initial begin
    int seg_len;
    int random_start;

    // empty store: rejected before any criterion is looked at
    push_take(MODE_ANY, 4'd3, 0, 0, 1'b0, 1'b0, 1'b0);
    push_take(MODE_BOTH, 4'd3, 0, 0, 1'b0, 1'b0, 1'b0);
    push_deliver(4'd0, VAL_MIN);
    push_deliver(4'd15, VAL_MAX);
    push_deliver(4'd5, 0);
    push_deliver(4'd10, -1);
    push_deliver(4'd5, 100);
    // missing criteria
    push_take(MODE_WINDOW, 4'd0, VAL_MIN, VAL_MAX, 1'b1, 1'b1, 1'b0);
    push_take(MODE_WINDOW, 4'd0, VAL_MIN, VAL_MAX, 1'b1, 1'b0, 1'b1);
    push_take(MODE_TYPE, 4'd15, VAL_MIN, VAL_MAX, 1'b0, 1'b1, 1'b1);
    push_take(MODE_BOTH, 4'd5, VAL_MIN, VAL_MAX, 1'b1, 1'b1, 1'b0);
    push_take(MODE_BOTH, 4'd5, VAL_MIN, VAL_MAX, 1'b0, 1'b1, 1'b1);
    // inverted window, absent type
    push_take(MODE_WINDOW, 4'd0, 10, -10, 1'b0, 1'b1, 1'b1);
    push_take(MODE_TYPE, 4'd7, 0, 0, 1'b1, 1'b0, 1'b0);
    push_take(MODE_WINDOW, 4'd9, VAL_MIN, VAL_MIN, 1'b0, 1'b1, 1'b1);
    push_take(MODE_TYPE, 4'd15, 0, 0, 1'b1, 1'b0, 1'b0);
    push_take(MODE_BOTH, 4'd5, 50, 200, 1'b1, 1'b1, 1'b1);
    push_take(MODE_WINDOW, 4'd0, VAL_MIN, VAL_MAX, 1'b0, 1'b1, 1'b1);
    push_take(MODE_ANY, 4'd15, VAL_MAX, VAL_MIN, 1'b0, 1'b0, 1'b0);
    push_take(MODE_ANY, 4'd0, 0, 0, 1'b1, 1'b1, 1'b1);

    random_start = request_q.size();
    // start with a fill past the top so a full drop is always reached
    for (int i = 0; i < STORE_DEPTH + 6; i++)
      push_deliver(rand_type(), rand_value());
    while (request_q.size() - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0: begin
          seg_len = $urandom_range(60, 72);
          for (int i = 0; i < seg_len; i++)
            push_deliver(rand_type(), rand_value());
        end
        1: begin
          seg_len = $urandom_range(30, 70);
          for (int i = 0; i < seg_len; i++) begin
            if ($urandom_range(9) < 6)
              push_take(MODE_ANY, 4'($urandom_range(15)), $urandom, $urandom,
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
            else
              push_random_take(1'b1);
          end
        end
        default: begin
          for (int i = 0; i < 40; i++) begin
            case ($urandom_range(9))
              0, 1, 2, 3, 4: push_deliver(rand_type(), rand_value());
              9: push_random_take(1'b0);
              default: push_random_take(1'b1);
            endcase
          end
        end
      endcase
    end
    total_items = request_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0 && predicted_rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
src/fmeq_pkg.sv
src/fmeq_cell.sv
src/fmeq_pick.sv
src/first_match_extract_queue_top.sv
dv/first_match_extract_queue_top_tb.sv
